// ----- design/rleb_pkg.sv -----
// ----------------------------------------------------------------------------
// rleb_pkg - shared types and constants for the RLE pitched blitter
// Token layout, configuration register indexes, widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rleb_pkg;

	localparam int SEG_ADDR_W = 25;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_DEST_COL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_ROW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd4;

	localparam logic [11:0] RST_DEST_COL     = 12'd0;
	localparam logic [11:0] RST_DEST_ROW     = 12'd0;
	localparam logic [13:0] RST_LINE_PITCH   = 14'd640;
	localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
	localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;

	localparam int MIN_WIDTH  = 8;
	localparam int MIN_HEIGHT = 1;

	typedef struct packed {
		logic [7:0] color;
		logic [7:0] count;
	} token_t;

	typedef struct packed {
		logic [11:0] dest_col;
		logic [11:0] dest_row;
		logic [13:0] line_pitch;
		logic [12:0] image_width;
		logic [12:0] image_height;
	} cfg_t;

endpackage

`default_nettype wire

// ----- design/rleb_front.sv -----
// ----------------------------------------------------------------------------
// rleb_front - token intake and classification
// Turns a literal or run token into a pixel count and drops empty runs.
// ----------------------------------------------------------------------------
`default_nettype none

module rleb_front (
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            is_run,
	input  wire logic [7:0]      pixel_color,
	input  wire logic [7:0]      run_length,
	input  wire logic            q_full,
	output logic                 push,
	output rleb_pkg::token_t     push_data
);

	logic [7:0] count;

	always_comb begin
		count = is_run ? run_length : 8'd1;
		in_ready = !q_full;
		push = in_valid && !q_full && (count != 8'd0);
		push_data.color = pixel_color;
		push_data.count = count;
	end

endmodule

`default_nettype wire

// ----- design/rleb_queue.sv -----
// ----------------------------------------------------------------------------
// rleb_queue - two-entry token queue
// Decouples token intake from segment generation.
// ----------------------------------------------------------------------------
`default_nettype none

module rleb_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rleb_pkg::token_t push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  not_empty,
	output rleb_pkg::token_t      pop_data
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	rleb_pkg::token_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/rleb_back.sv -----
// ----------------------------------------------------------------------------
// rleb_back - segment generator
// Walks a token across image rows, one row segment per cycle while the output is not stalled, and tracks
// column, row address and pixel count of the current image.
// ----------------------------------------------------------------------------
`default_nettype none

module rleb_back #(
	parameter int MAX_DIM   = 4096,
	parameter int ADDR_BITS = 25
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rleb_pkg::cfg_t                cfg,
	input  wire logic                          q_not_empty,
	input  wire rleb_pkg::token_t              q_data,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [rleb_pkg::SEG_ADDR_W-1:0]    seg_address,
	output logic [7:0]                         seg_length,
	output logic [7:0]                         seg_color,
	output logic                               image_done,
	output logic                               last
);

	localparam int WB  = $clog2(MAX_DIM + 1);
	localparam int PWB = 2 * WB;
	localparam int SAW = rleb_pkg::SEG_ADDR_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_SEG
	} state_t;

	state_t           state_q;
	rleb_pkg::token_t tok_q;
	logic [7:0]       rem_q;
	logic [WB-1:0]    col_q;
	logic [ADDR_BITS-1:0] row_q;
	logic [PWB-1:0]   pw_q;

	logic [WB-1:0]        width_q;
	logic [PWB-1:0]       size_q;
	logic [ADDR_BITS-1:0] base_q;

	logic                 out_valid_q;
	logic [SAW-1:0]       addr_q;
	logic [7:0]           len_q;
	logic [7:0]           color_q;
	logic                 done_q;
	logic                 last_q;

	logic [31:0]          w32;
	logic [31:0]          h32;
	logic [WB-1:0]        width_d;
	logic [WB-1:0]        height_d;
	logic [25:0]          base_prod;
	logic [32:0]          base_sum;

	logic [WB-1:0]        room_row;
	logic [PWB-1:0]       room_img;
	logic [7:0]           seg_len;
	logic [WB-1:0]        new_col;
	logic [PWB-1:0]       new_pw;
	logic [7:0]           rem_new;
	logic                 row_wrap;
	logic                 done;
	logic                 seg_last;
	logic [ADDR_BITS-1:0] row_next;
	logic [ADDR_BITS-1:0] addr_now;
	logic [ADDR_BITS+SAW-1:0] addr_ext;
	logic                 out_free;
	logic                 fire;

	always_comb begin
		w32 = 32'(cfg.image_width);
		h32 = 32'(cfg.image_height);
		if (w32 < 32'(rleb_pkg::MIN_WIDTH)) begin
			w32 = 32'(rleb_pkg::MIN_WIDTH);
		end else if (w32 > 32'(MAX_DIM)) begin
			w32 = 32'(MAX_DIM);
		end
		if (h32 < 32'(rleb_pkg::MIN_HEIGHT)) begin
			h32 = 32'(rleb_pkg::MIN_HEIGHT);
		end else if (h32 > 32'(MAX_DIM)) begin
			h32 = 32'(MAX_DIM);
		end
		width_d   = WB'(w32);
		height_d  = WB'(h32);
		base_prod = 26'(cfg.dest_row) * 26'(cfg.line_pitch);
		base_sum  = 33'(base_prod) + 33'(cfg.dest_col);
	end

	always_ff @(posedge clk) begin
		width_q <= width_d;
		size_q  <= PWB'(width_d) * PWB'(height_d);
		base_q  <= base_sum[ADDR_BITS-1:0];
	end

	always_comb begin
		room_row = width_q - col_q;
		room_img = size_q - pw_q;
		seg_len  = rem_q;
		if (PWB'(room_row) < PWB'(seg_len)) begin
			seg_len = 8'(room_row);
		end
		if (room_img < PWB'(seg_len)) begin
			seg_len = 8'(room_img);
		end
		new_col  = col_q + WB'(seg_len);
		new_pw   = pw_q + PWB'(seg_len);
		rem_new  = rem_q - seg_len;
		row_wrap = (new_col >= width_q);
		done     = (new_pw >= size_q);
		seg_last = done || (rem_new == 8'd0);
		row_next = row_q + ADDR_BITS'(cfg.line_pitch);
		addr_now = row_q + ADDR_BITS'(col_q);
		addr_ext = {{SAW{1'b0}}, addr_now};
		out_free = !out_valid_q || out_ready;
		fire     = (state_q == ST_SEG) && out_free;
		pop      = q_not_empty && ((state_q == ST_IDLE) || (fire && seg_last));
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tok_q <= q_data;
		end
		if (fire) begin
			addr_q  <= addr_ext[SAW-1:0];
			len_q   <= seg_len;
			color_q <= tok_q.color;
			done_q  <= done;
			last_q  <= seg_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			pw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						rem_q   <= q_data.count;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if ((pw_q >= size_q) || (pw_q == '0)) begin
						col_q <= '0;
						row_q <= base_q;
						pw_q  <= '0;
					end else if (col_q >= width_q) begin
						col_q <= '0;
						row_q <= row_next;
					end
					state_q <= ST_SEG;
				end
				ST_SEG: begin
					if (fire) begin
						if (done) begin
							pw_q  <= '0;
							col_q <= '0;
						end else if (row_wrap) begin
							pw_q  <= new_pw;
							col_q <= '0;
						end else begin
							pw_q  <= new_pw;
							col_q <= new_col;
						end
						if (row_wrap) begin
							row_q <= row_next;
						end
						if (seg_last && pop) begin
							rem_q   <= q_data.count;
							state_q <= ST_START;
						end else if (seg_last) begin
							rem_q   <= rem_new;
							state_q <= ST_IDLE;
						end else begin
							rem_q <= rem_new;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign seg_address = addr_q;
	assign seg_length  = len_q;
	assign seg_color   = color_q;
	assign image_done  = done_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// ----- design/flagged_rle_pitched_blit.sv -----
// ----------------------------------------------------------------------------
// flagged_rle_pitched_blit - run-length decoder into a pitched frame buffer
// Literal and run tokens become row segments (address, length, colour).
// A token passes through the queue and a start state before the segment
// state writes its segments into the output register, one row per cycle
// while the output is not stalled; a waiting token is popped with the last.
// Reset: asynchronous; clears queue, image position and output valid, and
// loads the registers with their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module flagged_rle_pitched_blit #(
	parameter int MAX_DIM   = 4096,
	parameter int ADDR_BITS = 25
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                is_run,
	input  wire logic [7:0]                          pixel_color,
	input  wire logic [7:0]                          run_length,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [rleb_pkg::SEG_ADDR_W-1:0]          seg_address,
	output logic [7:0]                               seg_length,
	output logic [7:0]                               seg_color,
	output logic                                     image_done,
	output logic                                     last,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rleb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rleb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	rleb_pkg::cfg_t   cfg_q;
	rleb_pkg::token_t push_data;
	rleb_pkg::token_t pop_data;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_col     <= rleb_pkg::RST_DEST_COL;
			cfg_q.dest_row     <= rleb_pkg::RST_DEST_ROW;
			cfg_q.line_pitch   <= rleb_pkg::RST_LINE_PITCH;
			cfg_q.image_width  <= rleb_pkg::RST_IMAGE_WIDTH;
			cfg_q.image_height <= rleb_pkg::RST_IMAGE_HEIGHT;
		end else if (cfg_valid) begin
			case (cfg_index)
				rleb_pkg::CFG_DEST_COL:     cfg_q.dest_col     <= cfg_data[11:0];
				rleb_pkg::CFG_DEST_ROW:     cfg_q.dest_row     <= cfg_data[11:0];
				rleb_pkg::CFG_LINE_PITCH:   cfg_q.line_pitch   <= cfg_data[13:0];
				rleb_pkg::CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[12:0];
				rleb_pkg::CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	rleb_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.is_run      (is_run),
		.pixel_color (pixel_color),
		.run_length  (run_length),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	rleb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop_data  (pop_data)
	);

	rleb_back #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.seg_address (seg_address),
		.seg_length  (seg_length),
		.seg_color   (seg_color),
		.image_done  (image_done),
		.last        (last)
	);

endmodule

`default_nettype wire

// ----- design/rleb_checker.sv -----
// ----------------------------------------------------------------------------
// rleb_checker - port-level checks for the RLE pitched blitter
// Watches the output channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rleb_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [rleb_pkg::SEG_ADDR_W-1:0]  seg_address,
	input wire logic [7:0]                       seg_length,
	input wire logic [7:0]                       seg_color,
	input wire logic                             image_done,
	input wire logic                             last
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(seg_address)
			&& $stable(seg_length) && $stable(seg_color) && $stable(last))
		else $error("segment changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seg_length != 8'd0)
		else $error("empty segment");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> last)
		else $error("image end not on final segment of token");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a token's segments");

endmodule

bind flagged_rle_pitched_blit rleb_checker u_rleb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.seg_address (seg_address),
	.seg_length  (seg_length),
	.seg_color   (seg_color),
	.image_done  (image_done),
	.last        (last)
);

`default_nettype wire

// ----- bench/tb_flagged_rle_pitched_blit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flagged_rle_pitched_blit - self-checking bench for the RLE blitter
// Drives literal and run tokens and register writes through their
// valid/ready channels. A scoreboard tracks image position and
// configuration, predicts the row segments each accepted token produces,
// and checks every segment leaving the block against the oldest
// prediction. Directed corner cases come first, then three random phases
// with different idle patterns on each side.
// ----------------------------------------------------------------------------

module tb_flagged_rle_pitched_blit;

	localparam int MAX_DIM        = 4096;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_TOKENS   = 100;
	localparam int RECONFIG_EVERY = 20;

	typedef logic [rleb_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [rleb_pkg::CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [rleb_pkg::SEG_ADDR_W-1:0] addr_t;

	localparam cfg_idx_t CFG_FIRST_UNUSED = 3'd5;
	localparam cfg_idx_t CFG_LAST_UNUSED  = 3'd7;

	typedef struct {
		addr_t      address;
		logic [7:0] length;
		logic [7:0] color;
		logic       done;
		logic       last;
	} seg_t;

	class segment_tracker;
		logic [11:0] dest_col;
		logic [11:0] dest_row;
		logic [13:0] line_pitch;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [12:0] column_pos;
		addr_t       row_address;
		logic [24:0] pixels_written;
		seg_t        expected_segs[$];
		int          errors;

		function new();
			dest_col     = rleb_pkg::RST_DEST_COL;
			dest_row     = rleb_pkg::RST_DEST_ROW;
			line_pitch   = rleb_pkg::RST_LINE_PITCH;
			image_width  = rleb_pkg::RST_IMAGE_WIDTH;
			image_height = rleb_pkg::RST_IMAGE_HEIGHT;
			errors       = 0;
			clear_image();
		endfunction

		function void clear_image();
			column_pos     = '0;
			row_address    = '0;
			pixels_written = '0;
		endfunction

		function int unsigned eff_width();
			int unsigned w;

			w = 32'(image_width);
			if (w < 32'(rleb_pkg::MIN_WIDTH)) return 32'(rleb_pkg::MIN_WIDTH);
			if (w > 32'(MAX_DIM)) return 32'(MAX_DIM);
			return w;
		endfunction

		function int unsigned eff_height();
			int unsigned h;

			h = 32'(image_height);
			if (h < 32'(rleb_pkg::MIN_HEIGHT)) return 32'(rleb_pkg::MIN_HEIGHT);
			if (h > 32'(MAX_DIM)) return 32'(MAX_DIM);
			return h;
		endfunction

		function int pending();
			return expected_segs.size();
		endfunction

		function void write_register(cfg_idx_t idx, cfg_data_t data);
			case (idx)
				rleb_pkg::CFG_DEST_COL: dest_col = data[11:0];
				rleb_pkg::CFG_DEST_ROW: dest_row = data[11:0];
				rleb_pkg::CFG_LINE_PITCH: line_pitch = data[13:0];
				rleb_pkg::CFG_IMAGE_WIDTH: image_width = data[12:0];
				rleb_pkg::CFG_IMAGE_HEIGHT: image_height = data[12:0];
				default: ;
			endcase
		endfunction

		function void predict_segments(logic run, logic [7:0] color, logic [7:0] count);
			int unsigned remaining;
			int unsigned width;
			int unsigned size;
			int unsigned seg;
			int unsigned room;
			seg_t        s;

			remaining = run ? 32'(count) : 32'd1;
			width     = eff_width();
			size      = width * eff_height();
			if (remaining == 0) return;
			if (32'(pixels_written) >= size) clear_image();
			if (pixels_written == '0) begin
				column_pos  = '0;
				row_address = addr_t'(32'(dest_row) * 32'(line_pitch) + 32'(dest_col));
			end
			while (remaining > 0) begin
				if (32'(column_pos) >= width) begin
					column_pos  = '0;
					row_address = row_address + addr_t'(line_pitch);
				end
				seg = width - 32'(column_pos);
				if (remaining < seg) seg = remaining;
				room = size - 32'(pixels_written);
				if (room < seg) seg = room;
				s.address      = row_address + addr_t'(column_pos);
				s.length       = seg[7:0];
				s.color        = color;
				column_pos     = 13'(32'(column_pos) + seg);
				pixels_written = 25'(32'(pixels_written) + seg);
				remaining      = remaining - seg;
				if (32'(column_pos) >= width) begin
					column_pos  = '0;
					row_address = row_address + addr_t'(line_pitch);
				end
				s.done = (32'(pixels_written) >= size);
				if (s.done) begin
					clear_image();
					remaining = 0;
				end
				s.last = (remaining == 0);
				expected_segs.push_back(s);
			end
		endfunction

		function void check_segment(seg_t got);
			seg_t want;

			if (expected_segs.size() == 0) begin
				$error("segment with nothing outstanding: seg_address %0h", got.address);
				errors++;
				return;
			end
			want = expected_segs.pop_front();
			if (got.address !== want.address) begin
				$error("seg_address: expected %0h, actual %0h", want.address, got.address);
				errors++;
			end
			if (got.length !== want.length) begin
				$error("seg_length: expected %0d, actual %0d", want.length, got.length);
				errors++;
			end
			if (got.color !== want.color) begin
				$error("seg_color: expected %0h, actual %0h", want.color, got.color);
				errors++;
			end
			if (got.done !== want.done) begin
				$error("image_done: expected %0b, actual %0b", want.done, got.done);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       is_run;
	logic [7:0] pixel_color;
	logic [7:0] run_length;
	logic       out_valid;
	logic       out_ready = 1'b0;
	addr_t      seg_address;
	logic [7:0] seg_length;
	logic [7:0] seg_color;
	logic       image_done;
	logic       last;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_idx_t   cfg_index;
	cfg_data_t  cfg_data;

	segment_tracker tracker = new();
	seg_t           observed;
	int             quiet_cycles = 0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;

	flagged_rle_pitched_blit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.is_run      (is_run),
		.pixel_color (pixel_color),
		.run_length  (run_length),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.seg_address (seg_address),
		.seg_length  (seg_length),
		.seg_color   (seg_color),
		.image_done  (image_done),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				tracker.predict_segments(is_run, pixel_color, run_length);
			if (out_valid && out_ready) begin
				observed.address = seg_address;
				observed.length  = seg_length;
				observed.color   = seg_color;
				observed.done    = image_done;
				observed.last    = last;
				tracker.check_segment(observed);
			end
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL flagged_rle_pitched_blit");
				$finish;
			end
		end
	end

	// all driver tasks start and end on a falling edge
	task automatic send_token(logic run, logic [7:0] color, logic [7:0] count);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		is_run      = run;
		pixel_color = color;
		run_length  = count;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// drop the request and wait for every predicted segment to leave
	task automatic drain_segments();
		in_valid = 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic cfg_data_t random_reg_value(cfg_idx_t idx);
		int unsigned pick;

		pick = $urandom_range(0, 99);
		case (idx)
			rleb_pkg::CFG_LINE_PITCH:
				return (pick < 70) ? cfg_data_t'($urandom_range(8, 64))
					: cfg_data_t'($urandom_range(0, 16383));
			rleb_pkg::CFG_IMAGE_WIDTH: begin
				if (pick < 80) return cfg_data_t'($urandom_range(8, 40));
				if (pick < 90) return cfg_data_t'($urandom_range(0, 7));
				return cfg_data_t'($urandom_range(0, 16383));
			end
			rleb_pkg::CFG_IMAGE_HEIGHT: begin
				if (pick < 80) return cfg_data_t'($urandom_range(1, 6));
				if (pick < 90) return '0;
				return cfg_data_t'($urandom_range(0, 16383));
			end
			default: return cfg_data_t'($urandom_range(0, 16383));
		endcase
	endfunction

	task automatic random_reconfig();
		cfg_idx_t idx;

		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 9) == 0)
				idx = cfg_idx_t'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED));
			else
				idx = cfg_idx_t'($urandom_range(rleb_pkg::CFG_DEST_COL,
					rleb_pkg::CFG_IMAGE_HEIGHT));
			write_reg(idx, random_reg_value(idx));
		end
	endtask

	task automatic random_token();
		int unsigned pick;
		logic        run;
		logic [7:0]  color;
		logic [7:0]  count;

		pick  = $urandom_range(0, 99);
		color = 8'($urandom);
		count = 8'($urandom);
		run   = (pick >= 40);
		if (run && pick < 85)
			count = 8'($urandom_range(1, 40));
		else if (run && pick >= 95)
			count = '0;
		send_token(run, color, count);
	endtask

	task automatic run_phase(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		drain_segments();
		write_reg(rleb_pkg::CFG_DEST_COL, random_reg_value(rleb_pkg::CFG_DEST_COL));
		write_reg(rleb_pkg::CFG_DEST_ROW, random_reg_value(rleb_pkg::CFG_DEST_ROW));
		write_reg(rleb_pkg::CFG_LINE_PITCH, random_reg_value(rleb_pkg::CFG_LINE_PITCH));
		write_reg(rleb_pkg::CFG_IMAGE_WIDTH, random_reg_value(rleb_pkg::CFG_IMAGE_WIDTH));
		write_reg(rleb_pkg::CFG_IMAGE_HEIGHT, random_reg_value(rleb_pkg::CFG_IMAGE_HEIGHT));
		for (int i = 0; i < PHASE_TOKENS; i++) begin
			if (i % RECONFIG_EVERY == RECONFIG_EVERY - 1) begin
				drain_segments();
				random_reconfig();
			end else if (i == PHASE_TOKENS / 2 + 3) begin
				drain_segments();
			end
			random_token();
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		is_run      = 1'b0;
		pixel_color = '0;
		run_length  = '0;
		cfg_valid   = 1'b0;
		cfg_index   = rleb_pkg::CFG_DEST_COL;
		cfg_data    = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset configuration; literal ignores its count, empty run gives nothing
		send_token(1'b0, 8'h00, 8'hFF);
		send_token(1'b1, 8'hFF, 8'h00);
		send_token(1'b1, 8'hA5, 8'hFF);
		send_token(1'b0, 8'h5A, 8'h00);
		drain_segments();

		// far corner, widest pitch, narrowest image: addresses wrap, old count exceeds image
		write_reg(rleb_pkg::CFG_DEST_COL, 14'h3FFF);
		write_reg(rleb_pkg::CFG_DEST_ROW, 14'h3FFF);
		write_reg(rleb_pkg::CFG_LINE_PITCH, 14'h3FFF);
		write_reg(rleb_pkg::CFG_IMAGE_WIDTH, 14'd8);
		write_reg(rleb_pkg::CFG_IMAGE_HEIGHT, 14'd2);
		write_reg(CFG_LAST_UNUSED, 14'h3FFF);
		send_token(1'b1, 8'h11, 8'hFF);
		send_token(1'b0, 8'h22, 8'h81);
		send_token(1'b1, 8'h33, 8'd7);
		send_token(1'b1, 8'h44, 8'd9);
		send_token(1'b1, 8'h55, 8'd3);
		drain_segments();

		// width and height below range saturate, zero pitch
		write_reg(rleb_pkg::CFG_DEST_COL, 14'd0);
		write_reg(rleb_pkg::CFG_DEST_ROW, 14'd0);
		write_reg(rleb_pkg::CFG_LINE_PITCH, 14'd0);
		write_reg(rleb_pkg::CFG_IMAGE_WIDTH, 14'd0);
		write_reg(rleb_pkg::CFG_IMAGE_HEIGHT, 14'd0);
		send_token(1'b1, 8'h66, 8'd20);
		send_token(1'b0, 8'h77, 8'd1);
		send_token(1'b1, 8'h88, 8'd8);
		drain_segments();

		// width and height above range saturate
		write_reg(rleb_pkg::CFG_DEST_COL, 14'd100);
		write_reg(rleb_pkg::CFG_DEST_ROW, 14'd200);
		write_reg(rleb_pkg::CFG_LINE_PITCH, 14'd8);
		write_reg(rleb_pkg::CFG_IMAGE_WIDTH, 14'h1FFF);
		write_reg(rleb_pkg::CFG_IMAGE_HEIGHT, 14'h1FFF);
		send_token(1'b1, 8'h99, 8'hFF);
		send_token(1'b1, 8'hAA, 8'd128);
		send_token(1'b0, 8'hBB, 8'd0);
		drain_segments();

		// column left beyond a narrowed row
		write_reg(rleb_pkg::CFG_IMAGE_WIDTH, 14'd20);
		send_token(1'b1, 8'hCC, 8'd15);
		drain_segments();
		write_reg(rleb_pkg::CFG_IMAGE_WIDTH, 14'd8);
		send_token(1'b1, 8'hDD, 8'd10);
		drain_segments();

		// pixel count left beyond a shrunk image
		write_reg(rleb_pkg::CFG_IMAGE_HEIGHT, 14'd1);
		send_token(1'b1, 8'hEE, 8'd12);
		send_token(1'b0, 8'h01, 8'd0);

		run_phase(22, 63);
		run_phase(63, 22);
		run_phase(0, 0);
		drain_segments();

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("PASS flagged_rle_pitched_blit");
		else
			$display("FAIL flagged_rle_pitched_blit");
		$finish;
	end

endmodule
